// ===== design/assert_macros.svh =====
// Assertion macros shared by the band mask filter modules.
// Depends on nothing; each user includes it before its module header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked at every rising clock edge outside reset.
`define CWBM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define CWBM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/cwbm_pkg.sv =====
// Shared types and constants of the cross-window band mask filter.
// Used by every module of the block; depends on nothing.
package cwbm_pkg;

  localparam int PIX_W     = 8;
  localparam int FW_W      = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd2;

  localparam logic [PIX_W-1:0] BAND_LOW_RESET  = 8'd0;
  localparam logic [PIX_W-1:0] BAND_HIGH_RESET = 8'd255;
  localparam logic [FW_W-1:0]  FW_RESET        = 11'd640;

  // One column of the line store: gray of the older and newer row, edge of the newer row.
  typedef struct packed {
    logic [PIX_W-1:0] gray_old;
    logic [PIX_W-1:0] gray_new;
    logic [PIX_W-1:0] edge_val;
  } line_word_t;

  // Which neighbors of the cross lie inside the frame.
  typedef struct packed {
    logic left_ok;
    logic right_ok;
    logic up_ok;
    logic below_ok;
  } nbr_mask_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_out;
    logic             frame_done;
  } result_t;

endpackage

// ===== design/cwbm_line_mem.sv =====
// Line store of the band mask filter: one word per column, one write and
// one registered read port. Depends on cwbm_pkg.
module cwbm_line_mem
  import cwbm_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  line_word_t    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output line_word_t    rdata
);

  line_word_t mem [DEPTH];
  line_word_t rdata_r;

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/cwbm_cross_eval.sv =====
// Band test over the plus-shaped neighborhood of one stored pixel.
// Depends on cwbm_pkg for the line word and neighbor mask types.
module cwbm_cross_eval
  import cwbm_pkg::*;
(
  input  logic [PIX_W-1:0] band_low,
  input  logic [PIX_W-1:0] band_high,
  input  line_word_t       center,
  input  logic [PIX_W-1:0] left_gray,
  input  logic [PIX_W-1:0] right_gray,
  input  logic [PIX_W-1:0] below_gray,
  input  nbr_mask_t        mask,
  output logic [PIX_W-1:0] edge_out
);

  function automatic logic in_band(input logic [PIX_W-1:0] g,
                                   input logic [PIX_W-1:0] lo,
                                   input logic [PIX_W-1:0] hi);
    return (lo < g) && (g < hi);
  endfunction

  logic hit;

  always_comb begin
    hit = in_band(center.gray_new, band_low, band_high)
        | (mask.left_ok  & in_band(left_gray, band_low, band_high))
        | (mask.right_ok & in_band(right_gray, band_low, band_high))
        | (mask.up_ok    & in_band(center.gray_old, band_low, band_high))
        | (mask.below_ok & in_band(below_gray, band_low, band_high));
    edge_out = hit ? center.edge_val : '0;
  end

endmodule

// ===== design/cwbm_out_fifo.sv =====
// Two-word output queue that decouples the filter stage from the receiver.
// Depends on cwbm_pkg for the result type and on assert_macros.svh.
`include "assert_macros.svh"
module cwbm_out_fifo
  import cwbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  result_t    push_data,
  output logic [1:0] level,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_data
);

  result_t    data_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_data  = data_r[rd_ptr_r];
  assign level     = cnt_r;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wr_ptr_r] <= push_data;
    end
  end

  `CWBM_ASSERT(a_fifo_level, clk, rst_n, cnt_r != 2'd3, "output queue level out of range")
  `CWBM_ASSERT_IMPL(a_fifo_no_overflow, clk, rst_n, push && !pop, cnt_r != 2'd2, "output queue overflow")
  `CWBM_ASSERT_IMPL(a_fifo_ptrs, clk, rst_n, cnt_r == 2'd0 || cnt_r == 2'd2, wr_ptr_r == rd_ptr_r, "output queue pointers disagree with level")

endmodule

// ===== design/cross_window_band_mask_filter_core.sv =====
// Cross-window band mask filter: streaming line-store filter of an edge map.
// Depends on cwbm_pkg, cwbm_line_mem, cwbm_cross_eval, cwbm_out_fifo and
// assert_macros.svh.
//
// Input words pair a gray pixel with an edge pixel in raster order; a drain
// word (opcode 1) flushes the last row after the frame. A nonzero edge pixel
// survives when some gray pixel of its plus-shaped neighborhood lies strictly
// between band_low and band_high. Results lag the input by one row: the pixel
// word at row r+1, column c yields the result for row r, column c, and the
// drain words yield the last row, the final one carrying frame_done.
// One input word is taken per cycle while in_ready is high. A result passes
// the filter stage, which waits for the line memory read of the right neighbor,
// and then the output queue register before it appears at out_valid.
// Each word prefetches the next column's stored word.
// A two-word output queue holds results while the receiver stalls; in_ready
// drops only when that queue cannot take the result of a new word.
// Reset clears the column counter, row count, drain flag and queue at once and
// restores the register defaults; the line memory is not cleared and needs no
// clearing pass. The configuration port is always ready; write it only while
// the block is idle.
`include "assert_macros.svh"
module cross_window_band_mask_filter_core
  import cwbm_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_opcode,
  input  logic [PIX_W-1:0]     in_gray_pixel,
  input  logic [PIX_W-1:0]     in_edge_pixel,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     out_edge_out,
  output logic                 out_frame_done,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FW_W-1:0]      cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int EW = (AW + 1 > FW_W) ? AW + 1 : FW_W;
  localparam logic [EW-1:0] MAXW = EW'(MAX_WIDTH);

  // Configuration registers.
  logic [PIX_W-1:0] band_low_r;
  logic [PIX_W-1:0] band_high_r;
  logic [FW_W-1:0]  frame_width_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_low_r    <= BAND_LOW_RESET;
      band_high_r   <= BAND_HIGH_RESET;
      frame_width_r <= FW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BAND_LOW:    band_low_r    <= cfg_data[PIX_W-1:0];
        REG_BAND_HIGH:   band_high_r   <= cfg_data[PIX_W-1:0];
        REG_FRAME_WIDTH: frame_width_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame position state.
  logic [AW-1:0] col_r, col_nxt;
  logic [1:0]    rows_r, rows_nxt;
  logic          draining_r, draining_nxt;

  logic [EW-1:0] fw_ext, eff_w, col_inc;
  logic          row_last;
  logic          acc, go, go_res, go_drain, go_done;

  always_comb begin
    fw_ext   = EW'(frame_width_r);
    eff_w    = (fw_ext == '0) ? EW'(1) : ((fw_ext > MAXW) ? MAXW : fw_ext);
    col_inc  = EW'(col_r) + EW'(1);
    row_last = (col_inc >= eff_w);
  end

  assign acc = in_valid && in_ready;

  always_comb begin
    col_nxt      = col_r;
    rows_nxt     = rows_r;
    draining_nxt = draining_r;
    go           = 1'b0;
    go_res       = 1'b0;
    go_drain     = 1'b0;
    go_done      = 1'b0;
    if (acc) begin
      unique case (in_opcode)
        OP_PIXEL: begin
          // Pixel words are dropped while the last row drains.
          if (!draining_r) begin
            go     = 1'b1;
            go_res = (rows_r != 2'd0);
            if (row_last) begin
              col_nxt = '0;
              if (rows_r != 2'd2) begin
                rows_nxt = rows_r + 2'd1;
              end
            end else begin
              col_nxt = col_r + AW'(1);
            end
          end
        end
        OP_DRAIN: begin
          // A drain starts only at a row boundary with a completed row.
          if (draining_r || (col_r == '0 && rows_r != 2'd0)) begin
            go           = 1'b1;
            go_res       = 1'b1;
            go_drain     = 1'b1;
            draining_nxt = 1'b1;
            if (row_last) begin
              go_done      = 1'b1;
              col_nxt      = '0;
              rows_nxt     = 2'd0;
              draining_nxt = 1'b0;
            end else begin
              col_nxt = col_r + AW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      rows_r     <= 2'd0;
      draining_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      rows_r     <= rows_nxt;
      draining_r <= draining_nxt;
    end
  end

  // Filter stage, in the cycle after acceptance.
  logic             b_v_r, b_res_r;
  logic             b_drain_r, b_done_r, b_self_r;
  logic [AW-1:0]    b_col_r;
  nbr_mask_t        b_mask_r;
  logic [PIX_W-1:0] b_gray_r, b_edge_r;
  logic             fwd_v_r;
  line_word_t       fwd_word_r;
  line_word_t       cur_r, cur_nxt;
  logic [PIX_W-1:0] left_r;
  line_word_t       mem_rdata, rd_eff, wword;
  nbr_mask_t        mask_a;

  always_comb begin
    mask_a.left_ok  = (col_r != '0);
    mask_a.right_ok = !row_last;
    mask_a.up_ok    = rows_r[1];
    mask_a.below_ok = (in_opcode == OP_PIXEL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r   <= 1'b0;
      b_res_r <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      b_v_r   <= go;
      b_res_r <= go_res;
      // The word being written now may be the one prefetched for the next column.
      fwd_v_r <= go && b_v_r && (b_col_r == col_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      b_drain_r <= go_drain;
      b_done_r  <= go_done;
      b_self_r  <= (col_nxt == col_r);
      b_col_r   <= col_r;
      b_mask_r  <= mask_a;
      b_gray_r  <= in_gray_pixel;
      b_edge_r  <= in_edge_pixel;
    end
    fwd_word_r <= wword;
    if (b_v_r) begin
      cur_r  <= cur_nxt;
      left_r <= cur_r.gray_new;
    end
  end

  always_comb begin
    rd_eff         = fwd_v_r ? fwd_word_r : mem_rdata;
    wword.gray_old = cur_r.gray_new;
    wword.gray_new = b_drain_r ? cur_r.gray_new : b_gray_r;
    wword.edge_val = b_drain_r ? cur_r.edge_val : b_edge_r;
    // In a one-column frame the next column is the one just written.
    cur_nxt        = b_self_r ? wword : rd_eff;
  end

  cwbm_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_mem (
    .clk   (clk),
    .we    (b_v_r),
    .waddr (b_col_r),
    .wdata (wword),
    .re    (go),
    .raddr (col_nxt),
    .rdata (mem_rdata)
  );

  logic [PIX_W-1:0] filt_edge;

  cwbm_cross_eval u_cross_eval (
    .band_low   (band_low_r),
    .band_high  (band_high_r),
    .center     (cur_r),
    .left_gray  (left_r),
    .right_gray (rd_eff.gray_new),
    .below_gray (b_gray_r),
    .mask       (b_mask_r),
    .edge_out   (filt_edge)
  );

  result_t    push_data, out_data;
  logic [1:0] level;
  logic       pop;
  logic [2:0] load;

  always_comb begin
    push_data.edge_out   = filt_edge;
    push_data.frame_done = b_done_r;
  end

  cwbm_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (b_v_r && b_res_r),
    .push_data (push_data),
    .level     (level),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Words queued after this cycle, counting the result still in the filter stage.
  assign load           = 3'(level) + 3'(b_res_r) - 3'(pop);
  assign in_ready       = (load <= 3'd1);
  assign out_edge_out   = out_data.edge_out;
  assign out_frame_done = out_data.frame_done;

  `CWBM_ASSERT(a_rows_sat, clk, rst_n, rows_r != 2'd3, "row count beyond saturation")
  `CWBM_ASSERT_IMPL(a_drain_rows, clk, rst_n, draining_r, rows_r != 2'd0, "draining with no completed row")
  `CWBM_ASSERT_IMPL(a_stage_src, clk, rst_n, b_v_r, $past(in_valid && in_ready), "filter stage without an accepted word")
  `CWBM_ASSERT_IMPL(a_fwd_stage, clk, rst_n, fwd_v_r, b_v_r, "forwarding outside the filter stage")

endmodule

// ===== sim/tb_cross_window_band_mask_filter_core.sv =====
// Self-checking testbench of cross_window_band_mask_filter_core: raster frames with
// random stalls on both channels, checked against a line-store predictor kept here.
// Depends on cwbm_pkg and the RTL of the block.
module tb_cross_window_band_mask_filter_core;
  import cwbm_pkg::*;

  localparam int MAX_W        = 1024;
  localparam int RANDOM_WORDS = 950;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE_TICKS = 4;
  localparam int STALL_LIMIT  = 3000;
  localparam int PRINT_LIMIT  = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {GAPS_NONE, GAPS_LIGHT, GAPS_HEAVY} gap_mode_t;

  typedef struct {
    logic             op;
    logic [PIX_W-1:0] gray;
    logic [PIX_W-1:0] edge_v;
  } pixel_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_opcode = OP_PIXEL;
  logic [PIX_W-1:0]     in_gray_pixel = '0;
  logic [PIX_W-1:0]     in_edge_pixel = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIX_W-1:0]     out_edge_out;
  logic                 out_frame_done;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_BAND_LOW;
  logic [FW_W-1:0]      cfg_data = '0;

  cross_window_band_mask_filter_core #(
    .MAX_WIDTH(MAX_W)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_opcode(in_opcode),
    .in_gray_pixel(in_gray_pixel),
    .in_edge_pixel(in_edge_pixel),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_edge_out(out_edge_out),
    .out_frame_done(out_frame_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: two stored gray rows, the newer edge row and the raster position.
  logic [PIX_W-1:0] row_gray_new [MAX_W];
  logic [PIX_W-1:0] row_gray_old [MAX_W];
  logic [PIX_W-1:0] row_edge [MAX_W];
  int unsigned      col_pos = 0;
  int unsigned      rows_done = 0;
  bit               flushing = 0;
  logic [PIX_W-1:0] lo_thr = BAND_LOW_RESET;
  logic [PIX_W-1:0] hi_thr = BAND_HIGH_RESET;
  logic [FW_W-1:0]  width_reg = FW_RESET;

  result_t     pending_results[$];
  pixel_word_t pixel_words[$];
  int          errors = 0;
  int          results_seen = 0;
  int          words_sent = 0;
  gap_mode_t   gap_mode = GAPS_NONE;
  int          burst_left = 0;
  int          gap_left = 0;
  bit          hold_req = 0;
  bit          hold_taken = 0;
  int          hold_left = 0;
  bit          run_on = 0;
  int          run_left = 0;
  int          idle_cycles = 0;
  pixel_word_t cur_word;
  result_t     want;

  function automatic int unsigned eff_width();
    int unsigned w;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic bit in_band(logic [PIX_W-1:0] g);
    return (lo_thr < g) && (g < hi_thr);
  endfunction

  // Band test over the plus-shaped neighborhood of column c of the newer row.
  function automatic logic [PIX_W-1:0] cross_masked_edge(int unsigned c, int unsigned w,
                                                         bit below_ok,
                                                         logic [PIX_W-1:0] below);
    bit hit;
    hit = 0;
    if (row_edge[c] == '0) return '0;
    if (c > 0 && in_band(row_gray_old[c-1])) hit = 1;
    if (c + 1 < w && in_band(row_gray_new[c+1])) hit = 1;
    if (rows_done >= 2 && in_band(row_gray_old[c])) hit = 1;
    if (below_ok && in_band(below)) hit = 1;
    if (in_band(row_gray_new[c])) hit = 1;
    return hit ? row_edge[c] : '0;
  endfunction

  function automatic void filter_word(pixel_word_t wd);
    int unsigned w;
    int unsigned c;
    result_t     r;
    w = eff_width();
    c = col_pos;
    if (c >= MAX_W) c = MAX_W - 1;
    if (wd.op == OP_PIXEL) begin
      if (flushing) return;
      if (rows_done >= 1) begin
        r.edge_out = cross_masked_edge(c, w, 1'b1, wd.gray);
        r.frame_done = 1'b0;
        pending_results.push_back(r);
      end
      row_gray_old[c] = row_gray_new[c];
      row_gray_new[c] = wd.gray;
      row_edge[c] = wd.edge_v;
      if (c + 1 >= w) begin
        col_pos = 0;
        if (rows_done < 2) rows_done++;
      end else begin
        col_pos = c + 1;
      end
    end else begin
      if (!flushing) begin
        if (c != 0 || rows_done == 0) return;
        flushing = 1;
      end
      r.edge_out = cross_masked_edge(c, w, 1'b0, '0);
      row_gray_old[c] = row_gray_new[c];
      if (c + 1 >= w) begin
        r.frame_done = 1'b1;
        col_pos = 0;
        rows_done = 0;
        flushing = 0;
      end else begin
        r.frame_done = 1'b0;
        col_pos = c + 1;
      end
      pending_results.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    if (errors < PRINT_LIMIT)
      $display("result %0d: %s is %0d, expected %0d", results_seen, what, got, exp_val);
    errors++;
  endtask

  // Sender: bursts of words with random gaps, fed from the pending word queue.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        filter_word('{in_opcode, in_gray_pixel, in_edge_pixel});
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (pixel_words.size() > 0) begin
          cur_word = pixel_words.pop_front();
          in_opcode <= cur_word.op;
          in_gray_pixel <= cur_word.gray;
          in_edge_pixel <= cur_word.edge_v;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left = burst_left - 1;
          end else if (gap_mode == GAPS_LIGHT) begin
            burst_left = $urandom_range(1, 16);
            gap_left = $urandom_range(1, 3);
          end else if (gap_mode == GAPS_HEAVY) begin
            burst_left = $urandom_range(0, 6);
            gap_left = $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: alternating ready runs and short stalls, plus one long hold on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (run_left > 0) begin
      run_left <= run_left - 1;
      out_ready <= run_on;
    end else begin
      run_on <= !run_on;
      out_ready <= !run_on;
      if (run_on)
        run_left <= $urandom_range(0, 5);
      else if ($urandom_range(0, 7) == 0)
        run_left <= $urandom_range(40, 200);
      else
        run_left <= $urandom_range(0, 20);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, edge_out", out_edge_out, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_edge_out !== want.edge_out)
          report_mismatch("edge_out", out_edge_out, want.edge_out);
        if (out_frame_done !== want.frame_done)
          report_mismatch("frame_done", out_frame_done, want.frame_done);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FW_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BAND_LOW:    lo_thr = data[PIX_W-1:0];
      REG_BAND_HIGH:   hi_thr = data[PIX_W-1:0];
      REG_FRAME_WIDTH: width_reg = data;
      default: ;
    endcase
  endtask

  // Wait until every word is taken and every result is back, then give the
  // pipeline time for words that produce no result.
  task automatic settle();
    @(negedge clk);
    while (pixel_words.size() != 0 || in_valid || pending_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic push_word(input logic op, input logic [PIX_W-1:0] g,
                           input logic [PIX_W-1:0] e, input bit counted);
    pixel_words.push_back('{op, g, e});
    if (counted) words_sent++;
  endtask

  function automatic logic [PIX_W-1:0] rand_gray();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return PIX_W'($urandom_range(lo_thr, hi_thr));
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] rand_edge();
    case ($urandom_range(0, 7))
      0, 1, 2: return '0;
      3: return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] rand_thr();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [FW_W-1:0] rand_width();
    case ($urandom_range(0, 11))
      0: return '0;
      1, 2: return FW_W'($urandom_range(17, 48));
      default: return FW_W'($urandom_range(1, 16));
    endcase
  endfunction

  // One whole frame; a noisy frame also carries words the block must ignore.
  task automatic send_frame(input int unsigned w, input int unsigned rows, input bit noisy,
                            input bit band_mid, input gap_mode_t gaps);
    int unsigned r;
    int unsigned c;
    @(negedge clk);
    gap_mode = gaps;
    if (noisy) push_word(OP_DRAIN, rand_gray(), rand_edge(), 1'b0);
    for (r = 0; r < rows; r++) begin
      for (c = 0; c < w; c++) begin
        if (noisy && c != 0 && $urandom_range(0, 11) == 0)
          push_word(OP_DRAIN, rand_gray(), rand_edge(), 1'b0);
        push_word(OP_PIXEL, rand_gray(), rand_edge(), 1'b1);
      end
      if (band_mid && r == rows / 2 && r + 1 < rows) begin
        settle();
        write_reg(REG_BAND_LOW, rand_thr());
        write_reg(REG_BAND_HIGH, rand_thr());
        @(negedge clk);
      end
    end
    for (c = 0; c < w; c++) begin
      push_word(OP_DRAIN, rand_gray(), rand_edge(), 1'b1);
      if (noisy && c + 1 < w && $urandom_range(0, 5) == 0)
        push_word(OP_PIXEL, rand_gray(), rand_edge(), 1'b0);
    end
  endtask

  initial begin
    int unsigned rows;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Width zero acts as one: every pixel word is a row of its own.
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_BAND_LOW, 11'd10);
    write_reg(REG_BAND_HIGH, 11'd200);
    write_reg(REG_UNUSED, '1);
    @(negedge clk);
    push_word(OP_DRAIN, 8'd7, 8'd9, 1'b1);
    push_word(OP_PIXEL, 8'd100, 8'd255, 1'b1);
    push_word(OP_PIXEL, 8'd0, 8'd255, 1'b1);
    push_word(OP_PIXEL, 8'd255, 8'd255, 1'b1);
    push_word(OP_DRAIN, 8'd0, 8'd0, 1'b1);
    settle();

    // Narrow band with grays on and just inside its bounds; a drain word in
    // mid-row and a pixel word during the flush are both ignored.
    write_reg(REG_FRAME_WIDTH, 11'd3);
    write_reg(REG_BAND_LOW, 11'd50);
    write_reg(REG_BAND_HIGH, 11'd60);
    @(negedge clk);
    push_word(OP_PIXEL, 8'd51, 8'd0, 1'b1);
    push_word(OP_PIXEL, 8'd60, 8'd255, 1'b1);
    push_word(OP_PIXEL, 8'd50, 8'd128, 1'b1);
    push_word(OP_PIXEL, 8'd59, 8'd1, 1'b1);
    push_word(OP_DRAIN, 8'd55, 8'd55, 1'b1);
    push_word(OP_PIXEL, 8'd0, 8'd255, 1'b1);
    push_word(OP_PIXEL, 8'd255, 8'd200, 1'b1);
    push_word(OP_DRAIN, 8'd0, 8'd0, 1'b1);
    push_word(OP_PIXEL, 8'd55, 8'd77, 1'b1);
    push_word(OP_DRAIN, 8'd0, 8'd0, 1'b1);
    push_word(OP_DRAIN, 8'd0, 8'd0, 1'b1);
    settle();

    // The width shrinks below the current column in mid-frame, so the row
    // ends with the next pixel word.
    write_reg(REG_FRAME_WIDTH, 11'd4);
    @(negedge clk);
    push_word(OP_PIXEL, 8'd52, 8'd10, 1'b1);
    push_word(OP_PIXEL, 8'd3, 8'd20, 1'b1);
    push_word(OP_PIXEL, 8'd200, 8'd30, 1'b1);
    push_word(OP_PIXEL, 8'd58, 8'd40, 1'b1);
    push_word(OP_PIXEL, 8'd1, 8'd50, 1'b1);
    push_word(OP_PIXEL, 8'd2, 8'd60, 1'b1);
    push_word(OP_PIXEL, 8'd4, 8'd70, 1'b1);
    settle();
    write_reg(REG_FRAME_WIDTH, 11'd2);
    @(negedge clk);
    push_word(OP_PIXEL, 8'd9, 8'd80, 1'b1);
    push_word(OP_PIXEL, 8'd57, 8'd90, 1'b1);
    push_word(OP_PIXEL, 8'd8, 8'd100, 1'b1);
    push_word(OP_DRAIN, 8'd0, 8'd0, 1'b1);
    push_word(OP_DRAIN, 8'd0, 8'd0, 1'b1);
    settle();

    // All-ones width clamps to the largest row; the receiver holds off for a
    // long stretch while the sender keeps offering words.
    write_reg(REG_BAND_LOW, rand_thr());
    write_reg(REG_BAND_HIGH, rand_thr());
    write_reg(REG_FRAME_WIDTH, '1);
    send_frame(eff_width(), 2, 1'b0, 1'b0, GAPS_NONE);
    // The first row yields no results, so the hold starts once the second row flows.
    while (pixel_words.size() > 2 * eff_width() - 64) @(negedge clk);
    hold_req = 1;
    settle();

    words_sent = 0;
    write_reg(REG_FRAME_WIDTH, rand_width());
    while (words_sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 3) == 0) begin
        settle();
        if ($urandom_range(0, 1) == 0) write_reg(REG_BAND_LOW, rand_thr());
        if ($urandom_range(0, 1) == 0) write_reg(REG_BAND_HIGH, rand_thr());
        if ($urandom_range(0, 1) == 0) write_reg(REG_FRAME_WIDTH, rand_width());
      end
      rows = (eff_width() > 16) ? $urandom_range(1, 2) : $urandom_range(1, 5);
      send_frame(eff_width(), rows, $urandom_range(0, 2) == 0, $urandom_range(0, 4) == 0,
                 gap_mode_t'($urandom_range(0, 2)));
    end
    settle();
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
